/* hw/rtl/held_key_repeat_engine_unit_assert.svh */
// Assertion macros shared by the held key repeat engine RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef HELD_KEY_REPEAT_ENGINE_UNIT_ASSERT_SVH
`define HELD_KEY_REPEAT_ENGINE_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define HKRE_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define HKRE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hkre_pkg.sv */
// Package for the held key repeat engine: sizes, codes, beat and control types.
// No dependencies.
package hkre_pkg;

  localparam int MaxHeldKeys = 8;
  localparam int IdxW        = (MaxHeldKeys > 1) ? $clog2(MaxHeldKeys) : 1;
  localparam int CntW        = $clog2(MaxHeldKeys + 1);

  localparam int KeyW  = 8;
  localparam int TimeW = 32;
  localparam int ModeW = 2;

  // Event kinds carried in the mode field
  localparam logic [ModeW-1:0] ModeKeyDown = 2'd0;
  localparam logic [ModeW-1:0] ModeKeyUp   = 2'd1;
  localparam logic [ModeW-1:0] ModeTick    = 2'd2;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgInitialDelay = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeatPeriod = 1'd1;

  localparam logic [TimeW-1:0] ResetInitialDelay = 32'd600000000;
  localparam logic [TimeW-1:0] ResetRepeatPeriod = 32'd40000000;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key_code;
    logic             is_modifier;
    logic [TimeW-1:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] out_key;
    logic            is_repeat;
    logic            last_result;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFlush
  } state_e;

  typedef enum logic [1:0] {
    TblNone,
    TblInsert,
    TblRemove,
    TblWrite
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e          op;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] cd;
    logic [IdxW-1:0]  idx;
  } tbl_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             full;
    logic [CntW-1:0]  count;
    logic [KeyW-1:0]  rd_key;
    logic [TimeW-1:0] rd_cd;
  } tbl_stat_t;

endpackage

/* hw/rtl/hkre_key_table.sv */
// Held key table kept sorted by key code, with countdowns, as a row of cells.
// Depends on hkre_pkg.
module hkre_key_table import hkre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tbl_ctrl_t ctrl_i,
  output tbl_stat_t stat_o
);

  logic [KeyW-1:0]  key_q [MaxHeldKeys];
  logic [KeyW-1:0]  key_d [MaxHeldKeys];
  logic [TimeW-1:0] cd_q  [MaxHeldKeys];
  logic [TimeW-1:0] cd_d  [MaxHeldKeys];
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [MaxHeldKeys-1:0] lt, eq;
  logic [CntW-1:0]        rank;

  // Compare the key against every held cell; rank is both insert and match slot
  always_comb begin
    rank = '0;
    for (int i = 0; i < MaxHeldKeys; i++) begin
      lt[i] = (CntW'(i) < cnt_q) && (key_q[i] < ctrl_i.key);
      eq[i] = (CntW'(i) < cnt_q) && (key_q[i] == ctrl_i.key);
      rank  = rank + CntW'(lt[i]);
    end
  end

  // Shift cells up on insert, down on remove, or load one countdown
  always_comb begin
    key_d = key_q;
    cd_d  = cd_q;
    cnt_d = cnt_q;
    unique case (ctrl_i.op)
      TblInsert: begin
        for (int i = 1; i < MaxHeldKeys; i++) begin
          if (CntW'(i) > rank) begin
            key_d[i] = key_q[i-1];
            cd_d[i]  = cd_q[i-1];
          end
        end
        for (int i = 0; i < MaxHeldKeys; i++) begin
          if (CntW'(i) == rank) begin
            key_d[i] = ctrl_i.key;
            cd_d[i]  = ctrl_i.cd;
          end
        end
        cnt_d = cnt_q + CntW'(1);
      end
      TblRemove: begin
        for (int i = 0; i < MaxHeldKeys - 1; i++) begin
          if (CntW'(i) >= rank) begin
            key_d[i] = key_q[i+1];
            cd_d[i]  = cd_q[i+1];
          end
        end
        cnt_d = cnt_q - CntW'(1);
      end
      TblWrite: begin
        cd_d[ctrl_i.idx] = ctrl_i.cd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Cell payload needs no reset: cells above the count are never read
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cd_q  <= cd_d;
  end

  assign stat_o.hit    = |eq;
  assign stat_o.full   = (cnt_q == CntW'(MaxHeldKeys));
  assign stat_o.count  = cnt_q;
  assign stat_o.rd_key = key_q[ctrl_i.idx];
  assign stat_o.rd_cd  = cd_q[ctrl_i.idx];

endmodule

/* hw/rtl/held_key_repeat_engine_unit.sv */
// Top level of the held key repeat engine: sequencer, shared countdown unit,
// output register. Depends on hkre_pkg, hkre_key_table and the assertion header.
//
//  channel | direction | handshake           | beat
//  in      | in        | in_valid_i/in_stall_o   | in_item_t
//  out     | out       | out_valid_o/out_stall_i | out_item_t
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Key up is handled when it is accepted. Key down: insert, then hand the press beat over.
// Tick: accept, one step per held key, end of walk, flush; one shared subtract and
// compare unit walks the held keys in ascending key order.
// A stalled output holds the sequencer only when a second beat is ready behind it.
// Reset empties the table and loads the default delay and period; no sweep.
`include "held_key_repeat_engine_unit_assert.svh"

module held_key_repeat_engine_unit import hkre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TimeW-1:0]    cfg_data_i
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic             pend_valid_q, pend_valid_d;
  logic [KeyW-1:0]  pend_key_q, pend_key_d;
  logic             pend_rep_q, pend_rep_d;
  logic [TimeW-1:0] initial_delay_q, repeat_period_q;
  logic             out_valid_q;
  out_item_t        out_q;

  tbl_ctrl_t        tbl_ctrl;
  tbl_stat_t        tbl_stat;

  logic             in_accept, out_free, push;
  out_item_t        push_item;
  logic [TimeW:0]   diff;
  logic             expire;

  hkre_key_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tbl_ctrl),
    .stat_o (tbl_stat)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Shared unit: countdown minus elapsed, expiry when it does not exceed
  assign diff   = {1'b0, tbl_stat.rd_cd} - {1'b0, elapsed_q};
  assign expire = diff[TimeW] || (diff[TimeW-1:0] == '0);

  // Sequencer: next state, table control and output pushes
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    elapsed_d    = elapsed_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    pend_rep_d   = pend_rep_q;
    tbl_ctrl.op  = TblNone;
    tbl_ctrl.key = in_i.key_code;
    tbl_ctrl.cd  = initial_delay_q;
    tbl_ctrl.idx = ptr_q[IdxW-1:0];
    push         = 1'b0;
    push_item    = '0;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          case (in_i.mode)
            ModeKeyDown: begin
              if (!in_i.is_modifier && !tbl_stat.hit && !tbl_stat.full) begin
                tbl_ctrl.op  = TblInsert;
                pend_valid_d = 1'b1;
                pend_key_d   = in_i.key_code;
                pend_rep_d   = 1'b0;
                state_d      = StFlush;
              end
            end
            ModeKeyUp: begin
              if (!in_i.is_modifier && tbl_stat.hit) begin
                tbl_ctrl.op = TblRemove;
              end
            end
            ModeTick: begin
              elapsed_d    = in_i.elapsed;
              ptr_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = StWalk;
            end
            default: begin
            end
          endcase
        end
      end
      StWalk: begin
        if (ptr_q == tbl_stat.count) begin
          state_d = StFlush;
        end else if (!expire) begin
          tbl_ctrl.op = TblWrite;
          tbl_ctrl.cd = diff[TimeW-1:0];
          ptr_d       = ptr_q + CntW'(1);
        end else if (!pend_valid_q || out_free) begin
          // Hand the previous repeat over, not last, and hold this one back
          push                  = pend_valid_q;
          push_item.out_key     = pend_key_q;
          push_item.is_repeat   = 1'b1;
          push_item.last_result = 1'b0;
          tbl_ctrl.op  = TblWrite;
          tbl_ctrl.cd  = repeat_period_q;
          pend_valid_d = 1'b1;
          pend_key_d   = tbl_stat.rd_key;
          pend_rep_d   = 1'b1;
          ptr_d        = ptr_q + CntW'(1);
        end
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          push                  = 1'b1;
          push_item.out_key     = pend_key_q;
          push_item.is_repeat   = pend_rep_q;
          push_item.last_result = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ptr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      pend_valid_q <= pend_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: pending beat, tick time, output beat
  always_ff @(posedge clk_i) begin
    elapsed_q  <= elapsed_d;
    pend_key_q <= pend_key_d;
    pend_rep_q <= pend_rep_d;
    if (push) begin
      out_q <= push_item;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_delay_q <= ResetInitialDelay;
      repeat_period_q <= ResetRepeatPeriod;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgInitialDelay: initial_delay_q <= cfg_data_i;
        CfgRepeatPeriod: repeat_period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `HKRE_ASSERT_SAME(a_push_free, push, !out_valid_q || !out_stall_i, "output beat overwritten")
  `HKRE_ASSERT_SAME(a_idle_no_pend, state_q == StIdle, !pend_valid_q, "pending beat lost")
  `HKRE_ASSERT_SAME(a_ptr_range, state_q == StWalk, ptr_q <= tbl_stat.count, "walk overran")
  `HKRE_ASSERT_NEXT(a_tick_walk, in_accept && in_i.mode == ModeTick, state_q == StWalk, "tick not walked")

endmodule

/* verif/tb_held_key_repeat_engine_unit.sv */
// Self-checking testbench for held_key_repeat_engine_unit: directed table, then random phases.
// Depends on hkre_pkg and the RTL of the unit; expected beats come from an in-bench predictor.
module tb_held_key_repeat_engine_unit;
  import hkre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Event kind with no meaning to the unit
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  localparam int ItemsPerSetting = 16;
  localparam int NumSettings     = 6;
  localparam int DrainCycles     = 24;
  localparam int CycleLimit      = 400000;
  localparam int PoolSize        = 12;
  localparam int MaxReports      = 10;

  typedef struct {
    in_item_t ev;
    bit       typed;  // expectation written in the row itself
    bit       press;  // typed row expects one press beat of its own key
  } vector_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [TimeW-1:0]    cfg_data_i  = '0;

  // Predictor state: held-key table and register copies
  logic             held_valid [MaxHeldKeys];
  logic [KeyW-1:0]  held_key   [MaxHeldKeys];
  logic [TimeW-1:0] held_count [MaxHeldKeys];
  logic [TimeW-1:0] delay_reg;
  logic [TimeW-1:0] period_reg;

  out_item_t   fresh_beats[$];
  out_item_t   expected_beats[$];
  vector_row_t directed_rows[$];
  logic [KeyW-1:0] key_pool[PoolSize];
  logic [TimeW-1:0] delay_set[NumSettings];
  logic [TimeW-1:0] period_set[NumSettings];

  int idle_pct  = 31;
  int stall_pct = 31;
  int err_cnt   = 0;
  int sent_cnt  = 0;
  int tracked_cnt = 0;
  int beat_cnt  = 0;
  int cycle_cnt = 0;

  held_key_repeat_engine_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the beats one event causes and advance the held-key table.
  // Returns 1 when the event changed the table or produced a beat.
  function automatic bit predict_event(in_item_t ev);
    int        i;
    int        slot;
    int        pick;
    bit        seen[MaxHeldKeys];
    bit        changed;
    out_item_t beat;
    fresh_beats.delete();
    slot    = -1;
    changed = 1'b0;
    if (ev.mode == ModeKeyDown) begin
      if (ev.is_modifier) return 1'b0;
      for (i = 0; i < MaxHeldKeys; i++) begin
        if (held_valid[i] && held_key[i] == ev.key_code) return 1'b0;
      end
      for (i = 0; i < MaxHeldKeys; i++) begin
        if (!held_valid[i] && slot < 0) slot = i;
      end
      if (slot < 0) return 1'b0;
      held_valid[slot] = 1'b1;
      held_key[slot]   = ev.key_code;
      held_count[slot] = delay_reg;
      beat.out_key     = ev.key_code;
      beat.is_repeat   = 1'b0;
      beat.last_result = 1'b1;
      fresh_beats.push_back(beat);
      return 1'b1;
    end
    if (ev.mode == ModeKeyUp) begin
      if (ev.is_modifier) return 1'b0;
      for (i = 0; i < MaxHeldKeys; i++) begin
        if (held_valid[i] && held_key[i] == ev.key_code) begin
          held_valid[i] = 1'b0;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (ev.mode == ModeTick) begin
      for (i = 0; i < MaxHeldKeys; i++) seen[i] = 1'b0;
      // Walk held keys in ascending code order
      do begin
        pick = -1;
        for (i = 0; i < MaxHeldKeys; i++) begin
          if (held_valid[i] && !seen[i] && (pick < 0 || held_key[i] < held_key[pick]))
            pick = i;
        end
        if (pick >= 0) begin
          seen[pick] = 1'b1;
          changed    = 1'b1;
          if (held_count[pick] > ev.elapsed) begin
            held_count[pick] = held_count[pick] - ev.elapsed;
          end else begin
            held_count[pick] = period_reg;
            beat.out_key     = held_key[pick];
            beat.is_repeat   = 1'b1;
            beat.last_result = 1'b0;
            fresh_beats.push_back(beat);
          end
        end
      end while (pick >= 0);
      if (fresh_beats.size() > 0) begin
        beat = fresh_beats.pop_back();
        beat.last_result = 1'b1;
        fresh_beats.push_back(beat);
      end
      return changed;
    end
    return 1'b0;
  endfunction

  function automatic in_item_t make_event(logic [ModeW-1:0] mode, logic [KeyW-1:0] key,
                                          logic modifier, logic [TimeW-1:0] elapsed);
    in_item_t ev;
    ev.mode        = mode;
    ev.key_code    = key;
    ev.is_modifier = modifier;
    ev.elapsed     = elapsed;
    return ev;
  endfunction

  function automatic void add_row(logic [ModeW-1:0] mode, logic [KeyW-1:0] key,
                                  logic modifier, logic [TimeW-1:0] elapsed,
                                  bit typed, bit press);
    vector_row_t row;
    row.ev    = make_event(mode, key, modifier, elapsed);
    row.typed = typed;
    row.press = press;
    directed_rows.push_back(row);
  endfunction

  // Draw one event, mostly on a small pool of keys so downs and ups meet held keys
  function automatic in_item_t random_event();
    in_item_t        ev;
    int              pick;
    longint unsigned span;
    span = 2 * longint'(period_reg);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    case ($urandom_range(0, 9))
      0:       ev.elapsed = '0;
      1, 2, 3,
      4, 5:    ev.elapsed = $urandom_range(0, 32'(span));
      6:       ev.elapsed = $urandom;
      7:       ev.elapsed = 32'hFFFF_FFFF;
      default: ev.elapsed = $urandom_range(0, delay_reg);
    endcase
    ev.is_modifier = ($urandom_range(0, 9) == 0);
    ev.key_code    = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                 : key_pool[$urandom_range(0, PoolSize - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 38)      ev.mode = ModeKeyDown;
    else if (pick < 65) ev.mode = ModeKeyUp;
    else if (pick < 96) ev.mode = ModeTick;
    else                ev.mode = ModeUnused;
    return ev;
  endfunction

  // Offer one event beat, hold it until accepted, then queue what it should cause
  task automatic send_event(in_item_t ev, bit typed, bit press);
    bit        tracked;
    out_item_t beat;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracked = predict_event(ev);
    if (typed) begin
      if (press) begin
        beat.out_key     = ev.key_code;
        beat.is_repeat   = 1'b0;
        beat.last_result = 1'b1;
        expected_beats.push_back(beat);
      end
    end else begin
      foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
    end
    sent_cnt++;
    if (tracked) tracked_cnt++;
  endtask

  // Drop valid, wait for every expected beat, then let the unit settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers back to back; valid stays high between the two beats
  task automatic load_setting(logic [TimeW-1:0] delay, logic [TimeW-1:0] period);
    int reg_idx;
    for (reg_idx = 0; reg_idx < 2; reg_idx++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (reg_idx == 0) ? CfgInitialDelay : CfgRepeatPeriod;
      cfg_data_i  <= (reg_idx == 0) ? delay : period;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    delay_reg  = delay;
    period_reg = period;
  endtask

  // Check each accepted result beat against the oldest expectation; drive random stall
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beat_cnt++;
      if (expected_beats.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("unexpected beat: key %02h repeat %0b last %0b",
                   out_o.out_key, out_o.is_repeat, out_o.last_result);
      end else begin
        want = expected_beats.pop_front();
        if (out_o.out_key !== want.out_key || out_o.is_repeat !== want.is_repeat ||
            out_o.last_result !== want.last_result) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("beat mismatch: expected key %02h repeat %0b last %0b, got %02h %0b %0b",
                     want.out_key, want.is_repeat, want.last_result,
                     out_o.out_key, out_o.is_repeat, out_o.last_result);
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int p;
    int start_cnt;
    for (p = 0; p < MaxHeldKeys; p++) begin
      held_valid[p] = 1'b0;
      held_key[p]   = '0;
      held_count[p] = '0;
    end
    delay_reg  = ResetInitialDelay;
    period_reg = ResetRepeatPeriod;
    for (p = 0; p < PoolSize; p++) key_pool[p] = 8'($urandom);

    delay_set[0] = 32'd1;           period_set[0] = 32'd1;
    delay_set[1] = 32'hFFFF_FFFF;   period_set[1] = 32'hFFFF_FFFF;
    delay_set[2] = 32'd1;           period_set[2] = 32'hFFFF_FFFF;
    delay_set[3] = 32'hFFFF_FFFF;   period_set[3] = 32'd1;
    delay_set[4] = $urandom_range(1, 20);
    period_set[4] = $urandom_range(1, 20);
    delay_set[5] = $urandom_range(1, 32'hFFFF_FFFF);
    period_set[5] = $urandom_range(1, 32'hFFFF_FFFF);

    // Directed rows run on the reset register values
    add_row(ModeTick,    8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0); // empty table
    add_row(ModeKeyDown, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'hFF, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h00, 1'b0, 32'h0000_0000, 1'b1, 1'b0); // already held
    add_row(ModeKeyDown, 8'h10, 1'b1, 32'h0000_0000, 1'b1, 1'b0); // modifier down
    add_row(ModeKeyUp,   8'h00, 1'b1, 32'h0000_0000, 1'b1, 1'b0); // modifier up
    add_row(ModeUnused,  8'hAA, 1'b0, 32'h1234_5678, 1'b1, 1'b0);
    add_row(ModeTick,    8'h5A, 1'b0, 32'd0,         1'b0, 1'b0);
    add_row(ModeTick,    8'h00, 1'b0, 32'd599999999, 1'b0, 1'b0);
    add_row(ModeTick,    8'h00, 1'b0, 32'd1,         1'b0, 1'b0); // exact expiry
    add_row(ModeTick,    8'h00, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(ModeKeyUp,   8'h55, 1'b0, 32'h0000_0000, 1'b1, 1'b0); // key not held
    add_row(ModeKeyUp,   8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_row(ModeKeyDown, 8'h80, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h40, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h20, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h10, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h08, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h04, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h02, 1'b0, 32'h0000_0000, 1'b1, 1'b1);
    add_row(ModeKeyDown, 8'h33, 1'b0, 32'h0000_0000, 1'b1, 1'b0); // table full
    add_row(ModeTick,    8'h00, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0); // every key repeats
    add_row(ModeKeyUp,   8'h40, 1'b0, 32'h0000_0000, 1'b1, 1'b0);
    add_row(ModeKeyDown, 8'h33, 1'b0, 32'h0000_0000, 1'b1, 1'b1); // takes the freed slot
    add_row(ModeTick,    8'h00, 1'b0, 32'd0,         1'b0, 1'b0);

    // Hold reset, then release it before the directed rows
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].press);

    // Random phases, one per register setting; the second runs without idling or output stalls
    for (p = 0; p < NumSettings; p++) begin
      wait_drained();
      idle_pct  = (p == 1) ? 0 : 31;
      stall_pct = (p == 1) ? 0 : 31;
      load_setting(delay_set[p], period_set[p]);
      start_cnt = sent_cnt;
      while (sent_cnt - start_cnt < ItemsPerSetting) begin
        if ($urandom_range(0, 24) == 0) wait_drained();
        send_event(random_event(), 1'b0, 1'b0);
      end
    end
    wait_drained();

    $display("sent %0d events (%0d touched the table), checked %0d result beats",
             sent_cnt, tracked_cnt, beat_cnt);
    $display("covered reset values and %0d register settings, %0d mismatches",
             NumSettings, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
